// ===== src/dsd_pkg.sv =====
package dsd_pkg;

  localparam int DEF_FRAME_CAPACITY = 512;
  localparam int DEF_HEADER_BYTES   = 6;

  localparam logic [7:0] SYM_DLE = 8'h10;
  localparam logic [7:0] SYM_STX = 8'h02;
  localparam logic [7:0] SYM_ETX = 8'h03;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TIMEOUT   = 3'd1;  // also empty frame
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_SHORT     = 3'd3;
  localparam logic [2:0] ST_EMPTY_PL  = 3'd4;
  localparam logic [2:0] ST_BEYOND    = 3'd5;
  localparam logic [2:0] ST_TOO_LARGE = 3'd6;
  localparam logic [2:0] ST_RESTART   = 3'd7;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS    = 1'd1;

  localparam logic [7:0]  RST_PAYLOAD_CAPACITY = 8'd255;
  localparam logic [15:0] RST_TIMEOUT_TICKS    = 16'd1500;

  typedef struct packed {
    logic [7:0]  payload_capacity;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic [7:0] out_index;
    logic [7:0] payload_len;
    logic [2:0] status;
    logic       last;
  } res_t;

endpackage

// ===== src/dsd_cfg.sv =====
module dsd_cfg
  import dsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.payload_capacity <= RST_PAYLOAD_CAPACITY;
      cfg.timeout_ticks    <= RST_TIMEOUT_TICKS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PAYLOAD_CAPACITY: cfg.payload_capacity <= cfg_data[7:0];
        REG_TIMEOUT_TICKS:    cfg.timeout_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/dsd_core.sv =====
module dsd_core
  import dsd_pkg::*;
#(
  parameter int FRAME_CAPACITY = DEF_FRAME_CAPACITY,
  parameter int HEADER_BYTES   = DEF_HEADER_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_valid,
  output logic       s_ready,
  input  logic       s_action,
  input  logic [7:0] s_byte,
  input  cfg_t       cfg,
  input  logic       out_free,
  output res_t       res,
  output logic       res_load
);

  localparam int POS_W = $clog2(FRAME_CAPACITY + 1);
  localparam int CMP_W = ((POS_W > 9) ? POS_W : 9) + 1;
  localparam logic [CMP_W-1:0] CAP   = CMP_W'(FRAME_CAPACITY);
  localparam logic [CMP_W-1:0] HB    = CMP_W'(HEADER_BYTES);
  localparam logic [CMP_W-1:0] HB_M1 = CMP_W'(HEADER_BYTES - 1);

  // input register
  logic       in_valid;
  logic       in_action;
  logic [7:0] in_byte;
  logic       fire;

  // frame state
  logic             inside_frame,   inside_frame_next;
  logic             escape_pending, escape_pending_next;
  logic [POS_W-1:0] frame_position, frame_position_next;
  logic [7:0]       header_length,  header_length_next;
  logic [15:0]      tick_count,     tick_count_next;

  logic [15:0]      tick_inc;
  logic [15:0]      tick_limit;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] hl_x;
  logic [CMP_W-1:0] pl_idx;
  logic             do_store;
  logic             do_close;
  logic             do_finish;
  logic [2:0]       fin_status;

  assign fire     = in_valid && out_free;
  assign s_ready  = !in_valid || out_free;
  assign res_load = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_ready) begin
      in_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      in_action <= s_action;
      in_byte   <= s_byte;
    end
  end

  assign tick_inc   = tick_count + 16'd1;
  assign tick_limit = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
  assign pos_x      = CMP_W'(frame_position);
  assign hl_x       = CMP_W'(header_length);
  assign pl_idx     = pos_x - HB;

  always_comb begin
    inside_frame_next   = inside_frame;
    escape_pending_next = escape_pending;
    frame_position_next = frame_position;
    header_length_next  = header_length;
    tick_count_next     = tick_count;
    res                 = '0;
    do_store            = 1'b0;
    do_close            = 1'b0;
    do_finish           = 1'b0;
    fin_status          = ST_OK;

    if (in_action) begin
      if (tick_inc >= tick_limit) begin
        do_finish  = 1'b1;
        fin_status = ST_TIMEOUT;
      end else begin
        tick_count_next = tick_inc;
      end
    end else if (!inside_frame) begin
      // hunt for the start sequence
      if (escape_pending && in_byte == SYM_STX) begin
        inside_frame_next   = 1'b1;
        escape_pending_next = 1'b0;
        frame_position_next = '0;
        header_length_next  = '0;
      end else begin
        escape_pending_next = (in_byte == SYM_DLE);
      end
    end else if (!escape_pending) begin
      if (in_byte == SYM_DLE) begin
        escape_pending_next = 1'b1;
      end else begin
        do_store = 1'b1;
      end
    end else begin
      escape_pending_next = 1'b0;
      if (in_byte == SYM_ETX) begin
        do_close = 1'b1;
      end else if (in_byte == SYM_STX) begin
        res.valid           = 1'b1;
        res.payload_len     = header_length;
        res.status          = ST_RESTART;
        res.last            = 1'b1;
        frame_position_next = '0;
        header_length_next  = '0;
      end else begin
        do_store = 1'b1;
      end
    end

    if (do_store) begin
      if (pos_x >= CAP) begin
        do_finish  = 1'b1;
        fin_status = ST_OVERFLOW;
      end else begin
        frame_position_next = frame_position + POS_W'(1);
        if (pos_x == HB_M1) begin
          header_length_next = in_byte;
        end else if (pos_x >= HB && pl_idx < hl_x) begin
          res.valid       = 1'b1;
          res.out_byte    = in_byte;
          res.out_index   = pl_idx[7:0];
          res.payload_len = header_length;
        end
      end
    end

    if (do_close) begin
      do_finish = 1'b1;
      if (pos_x == '0) begin
        fin_status = ST_TIMEOUT;
      end else if (pos_x <= HB) begin
        fin_status = ST_SHORT;
      end else if (header_length == 8'd0) begin
        fin_status = ST_EMPTY_PL;
      end else if (HB + hl_x > pos_x) begin
        fin_status = ST_BEYOND;
      end else if (header_length > cfg.payload_capacity) begin
        fin_status = ST_TOO_LARGE;
      end else begin
        fin_status = ST_OK;
      end
    end

    if (do_finish) begin
      res.valid           = 1'b1;
      res.out_byte        = '0;
      res.out_index       = '0;
      res.payload_len     = header_length;
      res.status          = fin_status;
      res.last            = 1'b1;
      inside_frame_next   = 1'b0;
      escape_pending_next = 1'b0;
      frame_position_next = '0;
      header_length_next  = '0;
      tick_count_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_frame   <= 1'b0;
      escape_pending <= 1'b0;
      frame_position <= '0;
      header_length  <= '0;
      tick_count     <= '0;
    end else if (fire) begin
      inside_frame   <= inside_frame_next;
      escape_pending <= escape_pending_next;
      frame_position <= frame_position_next;
      header_length  <= header_length_next;
      tick_count     <= tick_count_next;
    end
  end

  // payload bytes only go out below the header length
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (fire && res.valid && !res.last) |-> (CMP_W'(res.out_index) < hl_x))
    else $error("payload index not below header length");

  // every closing status except restart drops back to hunting with a fresh timer
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && res.valid && res.last && res.status != ST_RESTART)
      |=> (!inside_frame && tick_count == 16'd0))
    else $error("frame state not cleared after closing status");

  // while hunting no frame bytes are counted
  a_hunt_clean: assert property (@(posedge clk) disable iff (rst)
    !inside_frame |-> (frame_position == '0 && header_length == 8'd0))
    else $error("frame counters nonzero while hunting");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos_x <= CAP)
    else $error("frame position beyond capacity");

endmodule

// ===== src/dsd_out.sv =====
module dsd_out
  import dsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  res_t        res,
  input  logic        res_load,
  output logic        out_free,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  logic       out_valid;
  logic [7:0] out_byte;
  logic [7:0] out_index;
  logic [7:0] out_len;
  logic [2:0] out_status;
  logic       out_last;

  assign out_free = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_load && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_load && res.valid) begin
      out_byte   <= res.out_byte;
      out_index  <= res.out_index;
      out_len    <= res.payload_len;
      out_status <= res.status;
      out_last   <= res.last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_len, out_index, out_byte};
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

endmodule

// ===== src/dle_stx_etx_payload_deframer.sv =====
// a result reaches the output through the input register, then the result register
// throughput: one input item per cycle while results are taken; a stalled result
// holds the core, and the input stalls once the input register is also full
// reset (rst, synchronous): back to hunting for DLE STX, timer and counters cleared,
// payload_capacity = 255, timeout_ticks = 1500, no result pending
module dle_stx_etx_payload_deframer
  import dsd_pkg::*;
#(
  parameter int FRAME_CAPACITY = DEF_FRAME_CAPACITY,
  parameter int HEADER_BYTES   = DEF_HEADER_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // rx_byte
  input  logic                 s_axis_tuser,   // action
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata,   // out_byte, out_index, payload_len
  output logic [2:0]           m_axis_tuser,   // status
  output logic                 m_axis_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_t cfg;
  res_t res;
  logic res_load;
  logic out_free;

  dsd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dsd_core #(
    .FRAME_CAPACITY (FRAME_CAPACITY),
    .HEADER_BYTES   (HEADER_BYTES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_axis_tvalid),
    .s_ready  (s_axis_tready),
    .s_action (s_axis_tuser),
    .s_byte   (s_axis_tdata),
    .cfg      (cfg),
    .out_free (out_free),
    .res      (res),
    .res_load (res_load)
  );

  dsd_out u_out (
    .clk           (clk),
    .rst           (rst),
    .res           (res),
    .res_load      (res_load),
    .out_free      (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsd_pkg::*;

  localparam int HB          = DEF_HEADER_BYTES;
  localparam int CAPACITY    = DEF_FRAME_CAPACITY;
  localparam int SETTLE_CYC  = 4;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_REPORTS = 10;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef struct packed {
    logic [7:0] pl_byte;
    logic [7:0] pl_index;
    logic [7:0] pl_len;
    logic [2:0] status;
    logic       last;
  } deframe_res_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = 8'h00;   // rx_byte
  logic                 s_axis_tuser = ACT_BYTE; // action
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [23:0]          m_axis_tdata;           // out_byte, out_index, payload_len
  logic [2:0]           m_axis_tuser;           // status
  logic                 m_axis_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_PAYLOAD_CAPACITY;
  logic [15:0]          cfg_data = 16'h0000;

  dle_stx_etx_payload_deframer uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // deframer state mirrored by the predictor
  logic        frame_open = 1'b0;
  logic        esc_seen   = 1'b0;
  int unsigned frame_pos  = 0;
  logic [7:0]  hdr_len    = 8'h00;
  logic [15:0] tick_cnt   = 16'h0000;
  logic [7:0]  cap_reg    = RST_PAYLOAD_CAPACITY;
  logic [15:0] tmo_reg    = RST_TIMEOUT_TICKS;

  deframe_res_t expected_q[$];
  int          mismatch_cnt = 0;
  int          items_sent   = 0;
  int          cycle_cnt    = 0;
  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  int          tick_pct     = 0;

  function automatic void end_attempt(logic [2:0] st);
    expected_q.push_back('{8'h00, 8'h00, hdr_len, st, 1'b1});
    frame_open = 1'b0;
    esc_seen   = 1'b0;
    frame_pos  = 0;
    hdr_len    = 8'h00;
    tick_cnt   = 16'h0000;
  endfunction

  function automatic void store_frame_byte(logic [7:0] b);
    int unsigned p;
    p = frame_pos;
    if (p >= CAPACITY) begin
      end_attempt(ST_OVERFLOW);
      return;
    end
    frame_pos = p + 1;
    if (p == HB - 1)
      hdr_len = b;
    else if (p >= HB && (p - HB) < hdr_len)
      expected_q.push_back('{b, 8'(p - HB), hdr_len, ST_OK, 1'b0});
  endfunction

  function automatic void close_frame_check();
    if (frame_pos == 0)
      end_attempt(ST_TIMEOUT);   // empty frame shares the timeout code
    else if (frame_pos <= HB)
      end_attempt(ST_SHORT);
    else if (hdr_len == 0)
      end_attempt(ST_EMPTY_PL);
    else if (HB + hdr_len > frame_pos)
      end_attempt(ST_BEYOND);
    else if (hdr_len > cap_reg)
      end_attempt(ST_TOO_LARGE);
    else
      end_attempt(ST_OK);
  endfunction

  function automatic void predict_deframe(logic act, logic [7:0] b);
    logic [15:0] lim;
    if (act == ACT_TICK) begin
      lim = (tmo_reg == 16'd0) ? 16'd1 : tmo_reg;
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= lim)
        end_attempt(ST_TIMEOUT);
    end else if (!frame_open) begin
      if (esc_seen && b == SYM_STX) begin
        frame_open = 1'b1;
        esc_seen   = 1'b0;
        frame_pos  = 0;
        hdr_len    = 8'h00;
      end else begin
        esc_seen = (b == SYM_DLE);
      end
    end else if (!esc_seen) begin
      if (b == SYM_DLE)
        esc_seen = 1'b1;
      else
        store_frame_byte(b);
    end else begin
      esc_seen = 1'b0;
      if (b == SYM_ETX) begin
        close_frame_check();
      end else if (b == SYM_STX) begin
        // restart keeps the frame open and the timer running
        expected_q.push_back('{8'h00, 8'h00, hdr_len, ST_RESTART, 1'b1});
        frame_pos = 0;
        hdr_len   = 8'h00;
      end else begin
        store_frame_byte(b);
      end
    end
  endfunction

  function automatic void note_fail(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // output side: random stall and result check
  always @(posedge clk) begin
    deframe_res_t exp_r;
    deframe_res_t got_r;
    if (rst)
      m_axis_tready <= 1'b0;
    else
      m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_r = '{m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                m_axis_tuser, m_axis_tlast};
      if (expected_q.size() == 0) begin
        note_fail($sformatf("unexpected result: byte=%h idx=%0d len=%0d st=%0d last=%b",
                            got_r.pl_byte, got_r.pl_index, got_r.pl_len,
                            got_r.status, got_r.last));
      end else begin
        exp_r = expected_q.pop_front();
        if (got_r !== exp_r)
          note_fail($sformatf({"mismatch: expected byte=%h idx=%0d len=%0d st=%0d last=%b,",
                               " got byte=%h idx=%0d len=%0d st=%0d last=%b"},
                              exp_r.pl_byte, exp_r.pl_index, exp_r.pl_len,
                              exp_r.status, exp_r.last,
                              got_r.pl_byte, got_r.pl_index, got_r.pl_len,
                              got_r.status, got_r.last));
      end
    end
  end

  task automatic send_item(input logic act, input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_deframe(act, b);
    items_sent++;
  endtask

  task automatic send_seq(input logic [7:0] seq[$]);
    foreach (seq[i]) send_item(ACT_BYTE, seq[i]);
  endtask

  // one frame byte with DLE stuffing, sometimes escaped needlessly, ticks mixed in
  task automatic put_data(input logic [7:0] b);
    if ($urandom_range(0, 99) < tick_pct)
      send_item(ACT_TICK, 8'($urandom));
    if (b == SYM_DLE || (b != SYM_STX && b != SYM_ETX && $urandom_range(0, 7) == 0))
      send_item(ACT_BYTE, SYM_DLE);
    send_item(ACT_BYTE, b);
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return SYM_DLE;
      1: return SYM_STX;
      2: return SYM_ETX;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(input logic [7:0] len, input int n_pl, input bit closed);
    send_item(ACT_BYTE, SYM_DLE);
    send_item(ACT_BYTE, SYM_STX);
    repeat (HB - 1) put_data(rand_byte());
    put_data(len);
    repeat (n_pl) put_data(rand_byte());
    if (closed) begin
      send_item(ACT_BYTE, SYM_DLE);
      send_item(ACT_BYTE, SYM_ETX);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] cap, input logic [15:0] tmo);
    cfg_valid <= 1'b1;
    cfg_index <= REG_PAYLOAD_CAPACITY;
    cfg_data  <= {8'h00, cap};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cap_reg   = cap;
    cfg_index <= REG_TIMEOUT_TICKS;
    cfg_data  <= tmo;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tmo_reg   = tmo;
    cfg_valid <= 1'b0;
  endtask

  // hunting rules, stuffing, needless escape, a good frame at reset settings
  task automatic test_defaults_frame();
    logic [7:0] seq[$];
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    tick_pct     = 0;
    seq = {8'h41, SYM_DLE, 8'h41, SYM_STX, SYM_DLE, SYM_DLE, SYM_STX,
           8'h00, 8'hFF, SYM_DLE, SYM_DLE, 8'h7F, 8'h80, 8'h03,
           8'hFF, SYM_DLE, 8'h41, SYM_DLE, SYM_DLE, SYM_DLE, SYM_ETX};
    send_seq(seq);
    settle();
  endtask

  task automatic test_close_statuses();
    logic [7:0] seq[$];
    // empty frame
    seq = {SYM_DLE, SYM_STX, SYM_DLE, SYM_ETX};
    send_seq(seq);
    // header only
    seq = {SYM_DLE, SYM_STX, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h09, SYM_DLE, SYM_ETX};
    send_seq(seq);
    // zero payload length
    seq = {SYM_DLE, SYM_STX, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h00, 8'hAA,
           SYM_DLE, SYM_ETX};
    send_seq(seq);
    // length beyond the frame
    seq = {SYM_DLE, SYM_STX, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h05, 8'hAA, 8'hBB,
           SYM_DLE, SYM_ETX};
    send_seq(seq);
    // restart mid-frame, then a good frame with a trailing extra byte
    seq = {SYM_DLE, SYM_STX, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h02, 8'hAA,
           SYM_DLE, SYM_STX, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h01, 8'hCC, 8'hDD,
           SYM_DLE, SYM_ETX};
    send_seq(seq);
    settle();
    configure(8'd0, RST_TIMEOUT_TICKS);
    seq = {SYM_DLE, SYM_STX, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h01, 8'hEE,
           SYM_DLE, SYM_ETX};
    send_seq(seq);
    settle();
  endtask

  task automatic test_timeout();
    logic [7:0] seq[$];
    configure(8'd255, 16'd1);
    send_item(ACT_TICK, 8'hFF);
    settle();
    configure(8'd255, 16'd0);
    send_item(ACT_TICK, 8'h00);
    settle();
    configure(8'd255, 16'd4);
    seq = {SYM_DLE, SYM_STX, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h04, 8'hAA};
    send_seq(seq);
    repeat (4) send_item(ACT_TICK, 8'h5A);
    settle();
  endtask

  // a frame filling the buffer exactly, then one byte past it
  task automatic test_overflow();
    configure(8'd255, 16'd65535);
    send_frame(8'd255, CAPACITY - HB + 1, 1'b1);
    settle();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items,
                                     input logic [7:0] cap, input logic [15:0] tmo);
    int target;
    int pick;
    int len;
    int n;
    configure(cap, tmo);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    tick_pct     = 3;
    target = items_sent + n_items;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        case ($urandom_range(0, 19))
          0, 1:    len = 0;
          2:       len = $urandom_range(200, 255);
          default: len = $urandom_range(1, 20);
        endcase
        case ($urandom_range(0, 4))
          0:       n = $urandom_range(0, len);
          1:       n = len + $urandom_range(1, 4);
          default: n = len;
        endcase
        send_frame(8'(len), n, 1'b1);
      end else if (pick < 75) begin
        send_item(ACT_BYTE, SYM_DLE);
        send_item(ACT_BYTE, SYM_STX);
        repeat ($urandom_range(0, HB)) put_data(rand_byte());
        send_item(ACT_BYTE, SYM_DLE);
        send_item(ACT_BYTE, SYM_ETX);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 8)) send_item(ACT_BYTE, rand_byte());
      end else if (pick < 93) begin
        // left open, the next frame start restarts it
        len = $urandom_range(1, 20);
        send_frame(8'(len), $urandom_range(0, len), 1'b0);
      end else begin
        repeat ($urandom_range(1, 70)) send_item(ACT_TICK, 8'($urandom));
      end
    end
    settle();
  endtask

  initial begin
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_defaults_frame();
    test_close_statuses();
    test_timeout();
    test_overflow();
    test_random_traffic(0, 0, 200, 8'd255, 16'd60);
    test_random_traffic(82, 0, 200, 8'($urandom_range(1, 254)),
                        16'($urandom_range(100, 400)));
    test_random_traffic(0, 82, 200, 8'd12, 16'd65535);
    test_random_traffic(12, 12, 200, 8'($urandom_range(0, 255)),
                        16'($urandom_range(1, 200)));
    if (expected_q.size() != 0)
      note_fail($sformatf("%0d expected results never arrived", expected_q.size()));
    if (mismatch_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/dsd_pkg.sv
src/dsd_cfg.sv
src/dsd_core.sv
src/dsd_out.sv
src/dle_stx_etx_payload_deframer.sv
tb/tb.sv
